// File: rtl/tlvf_pkg.sv
`timescale 1ns / 1ps

package tlvf_pkg;

   localparam int STORE_BYTES_DEF = 256;
   localparam logic [7:0] START_OFFSET_RST = 8'd11;
   localparam int PAIR_BYTES = 2;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_FIND  = 2'd2,
      OP_SPARE = 2'd3
   } op_type;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_BAD_LENGTH = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND  = 2'd2;

   typedef enum logic [2:0] {
      RES_NONE  = 3'd0,
      RES_READ  = 3'd1,
      RES_FOUND = 3'd2,
      RES_BAD   = 3'd3,
      RES_MISS  = 3'd4
   } res_type;

   typedef struct packed {
      logic    write_en;
      logic    read_start;
      logic    find_start;
      logic    step;
      logic    rsp_load;
      res_type res_sel;
   } cmd_type;

   typedef struct packed {
      logic pair_fits;
      logic len_zero;
      logic kind_match;
   } stat_type;

endpackage

// File: rtl/tlvf_ctrl.sv
`timescale 1ns / 1ps

module tlvf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  tlvf_pkg::stat_type stat,
   output tlvf_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_READ  = 4'b0010,
      S_FETCH = 4'b0100,
      S_CHECK = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;
   logic      accept;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && slot_free);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in        = state_ff;
      cmd.write_en    = 1'b0;
      cmd.read_start  = 1'b0;
      cmd.find_start  = 1'b0;
      cmd.step        = 1'b0;
      cmd.rsp_load    = 1'b0;
      cmd.res_sel     = tlvf_pkg::RES_NONE;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (tlvf_pkg::op_type'(req_op))
                  tlvf_pkg::OP_WRITE: begin
                     cmd.write_en = 1'b1;
                     cmd.rsp_load = 1'b1;
                  end
                  tlvf_pkg::OP_READ: begin
                     cmd.read_start = 1'b1;
                     state_in       = S_READ;
                  end
                  tlvf_pkg::OP_FIND: begin
                     cmd.find_start = 1'b1;
                     state_in       = S_FETCH;
                  end
                  default: begin
                     cmd.rsp_load = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            cmd.rsp_load = 1'b1;
            cmd.res_sel  = tlvf_pkg::RES_READ;
            state_in     = S_IDLE;
         end
         S_FETCH: begin
            if (!stat.pair_fits) begin
               cmd.rsp_load = 1'b1;
               cmd.res_sel  = tlvf_pkg::RES_MISS;
               state_in     = S_IDLE;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.len_zero) begin
               cmd.rsp_load = 1'b1;
               cmd.res_sel  = tlvf_pkg::RES_BAD;
               state_in     = S_IDLE;
            end else if (stat.kind_match) begin
               cmd.rsp_load = 1'b1;
               cmd.res_sel  = tlvf_pkg::RES_FOUND;
               state_in     = S_IDLE;
            end else begin
               cmd.step = 1'b1;
               state_in = S_FETCH;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/tlvf_datapath.sv
`timescale 1ns / 1ps

module tlvf_datapath #(
   parameter int STORE_BYTES = tlvf_pkg::STORE_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [7:0]         csr_write_data,
   input  logic [7:0]         req_address,
   input  logic [7:0]         req_write_data,
   input  logic [7:0]         req_type_id,
   input  tlvf_pkg::cmd_type  cmd,
   output tlvf_pkg::stat_type stat,
   output logic [1:0]         rsp_status,
   output logic [8:0]         rsp_value_offset,
   output logic [7:0]         rsp_value_length,
   output logic [7:0]         rsp_read_data
);

   localparam int ADDR_W = $clog2(STORE_BYTES);
   localparam int POS_W  = $clog2(STORE_BYTES + 258);
   localparam logic [POS_W-1:0] LIMIT = POS_W'(STORE_BYTES);
   localparam logic [POS_W-1:0] PAIR  = POS_W'(tlvf_pkg::PAIR_BYTES);

   logic [7:0]       store [STORE_BYTES];
   logic [7:0]       start_ff, start_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       id_ff, id_in;
   logic             rd_ok_ff, rd_ok_in;
   logic [7:0]       rd_a_ff;
   logic [7:0]       rd_b_ff;
   logic [1:0]       status_ff, status_in;
   logic [8:0]       offset_ff, offset_in;
   logic [7:0]       length_ff, length_in;
   logic [7:0]       data_ff, data_in;

   logic [POS_W-1:0] addr_ext;
   logic             addr_ok;
   logic [POS_W-1:0] pos_next1;
   logic [POS_W-1:0] pos_value;
   logic [ADDR_W-1:0] rd_a_idx;
   logic [ADDR_W-1:0] rd_b_idx;

   assign addr_ext  = POS_W'(req_address);
   assign addr_ok   = addr_ext < LIMIT;
   assign pos_next1 = pos_ff + POS_W'(1);
   assign pos_value = pos_ff + PAIR;
   assign rd_a_idx  = cmd.read_start ? addr_ext[ADDR_W-1:0] : pos_ff[ADDR_W-1:0];
   assign rd_b_idx  = pos_next1[ADDR_W-1:0];

   assign stat.pair_fits  = pos_next1 < LIMIT;
   assign stat.len_zero   = rd_b_ff == 8'd0;
   assign stat.kind_match = rd_a_ff == id_ff;

   always_ff @(posedge clock) begin
      if (cmd.write_en && addr_ok) begin
         store[addr_ext[ADDR_W-1:0]] <= req_write_data;
      end
      rd_a_ff <= store[rd_a_idx];
      rd_b_ff <= store[rd_b_idx];
   end

   always_comb begin
      start_in = csr_write_enable ? csr_write_data : start_ff;
      id_in    = cmd.find_start ? req_type_id : id_ff;
      rd_ok_in = cmd.read_start ? addr_ok : rd_ok_ff;
      pos_in   = pos_ff;
      if (cmd.find_start) begin
         pos_in = POS_W'(start_ff);
      end else if (cmd.step) begin
         pos_in = pos_value + POS_W'(rd_b_ff);
      end
   end

   always_comb begin
      status_in = status_ff;
      offset_in = offset_ff;
      length_in = length_ff;
      data_in   = data_ff;
      if (cmd.rsp_load) begin
         status_in = tlvf_pkg::ST_OK;
         offset_in = 9'd0;
         length_in = 8'd0;
         data_in   = 8'd0;
         case (cmd.res_sel)
            tlvf_pkg::RES_READ: begin
               data_in = rd_ok_ff ? rd_a_ff : 8'd0;
            end
            tlvf_pkg::RES_FOUND: begin
               offset_in = pos_value[8:0];
               length_in = rd_b_ff;
            end
            tlvf_pkg::RES_BAD: begin
               status_in = tlvf_pkg::ST_BAD_LENGTH;
            end
            tlvf_pkg::RES_MISS: begin
               status_in = tlvf_pkg::ST_NOT_FOUND;
            end
            default: begin
               status_in = tlvf_pkg::ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= tlvf_pkg::START_OFFSET_RST;
      end else begin
         start_ff <= start_in;
      end
      pos_ff    <= pos_in;
      id_ff     <= id_in;
      rd_ok_ff  <= rd_ok_in;
      status_ff <= status_in;
      offset_ff <= offset_in;
      length_ff <= length_in;
      data_ff   <= data_in;
   end

   assign rsp_status       = status_ff;
   assign rsp_value_offset = offset_ff;
   assign rsp_value_length = length_ff;
   assign rsp_read_data    = data_ff;

endmodule

// File: rtl/tlv_record_finder.sv
`timescale 1ns / 1ps
// Write and unused op answer from idle; read passes through a read state; find walks
// each record as a fetch state (store fetch of the type/length pair) then a check state
// (compare and step), and ends in the fetch state when the walk runs off the store end;
// result registered. One request in flight; the next is taken once the walk is done and
// the result register is free. Reset (synchronous) clears the controller and the
// result valid and sets start_offset to 11; the byte store is not cleared.
module tlv_record_finder #(
   parameter int STORE_BYTES = tlvf_pkg::STORE_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_op,
   input  logic [7:0] req_address,
   input  logic [7:0] req_write_data,
   input  logic [7:0] req_type_id,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [8:0] rsp_value_offset,
   output logic [7:0] rsp_value_length,
   output logic [7:0] rsp_read_data
);

   tlvf_pkg::cmd_type  cmd;
   tlvf_pkg::stat_type stat;

   tlvf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   tlvf_datapath #(
      .STORE_BYTES (STORE_BYTES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_address      (req_address),
      .req_write_data   (req_write_data),
      .req_type_id      (req_type_id),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_status       (rsp_status),
      .rsp_value_offset (rsp_value_offset),
      .rsp_value_length (rsp_value_length),
      .rsp_read_data    (rsp_read_data)
   );

endmodule
